/* rtl/fsk_pkg.sv */
// shared types, codes and the quarter-wave sine table function for the fsk modulator
`default_nettype none

package fsk_pkg;

   // request command codes
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_SPACE_INCREMENT   = 2'd0,
      CSR_MARK_INCREMENT    = 2'd1,
      CSR_SAMPLES_PER_BIT   = 2'd2
   } csr_index_type;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned INC_BITS       = 32;
   localparam int unsigned SPB_BITS       = 16;
   localparam int unsigned BYTE_BITS      = 8;
   localparam int unsigned COUNT_BITS     = 4;

   localparam logic [SPB_BITS-1:0]   SPB_RESET     = 16'd441;
   localparam logic [COUNT_BITS-1:0] BITS_PER_BYTE = 4'd8;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_BITS = 2;

   // pi/2 in Q30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // ceil(2^64 / ((2n)(2n+1))) for the taylor terms, exact floor divide for small dividends
   localparam logic [63:0] TAYLOR_RECIP_1 = 64'((128'd1 << 64) / 128'd6   + 128'd1);
   localparam logic [63:0] TAYLOR_RECIP_2 = 64'((128'd1 << 64) / 128'd20  + 128'd1);
   localparam logic [63:0] TAYLOR_RECIP_3 = 64'((128'd1 << 64) / 128'd42  + 128'd1);
   localparam logic [63:0] TAYLOR_RECIP_4 = 64'((128'd1 << 64) / 128'd72  + 128'd1);
   localparam logic [63:0] TAYLOR_RECIP_5 = 64'((128'd1 << 64) / 128'd110 + 128'd1);
   localparam logic [63:0] TAYLOR_RECIP_6 = 64'((128'd1 << 64) / 128'd156 + 128'd1);
   localparam logic [63:0] TAYLOR_RECIP_7 = 64'((128'd1 << 64) / 128'd210 + 128'd1);

   typedef struct packed {
      logic [INC_BITS-1:0] space_increment;
      logic [INC_BITS-1:0] mark_increment;
      logic [SPB_BITS-1:0] samples_per_bit;
   } cfg_type;

   // reciprocal of the divisor of taylor term n
   function automatic logic [63:0] taylor_recip(input int unsigned n);
      logic [63:0] r;
      unique case (n)
         1: r = TAYLOR_RECIP_1;
         2: r = TAYLOR_RECIP_2;
         3: r = TAYLOR_RECIP_3;
         4: r = TAYLOR_RECIP_4;
         5: r = TAYLOR_RECIP_5;
         6: r = TAYLOR_RECIP_6;
         default: r = TAYLOR_RECIP_7;
      endcase
      return r;
   endfunction

   // one quarter-wave entry, evaluated at elaboration only
   function automatic int unsigned quarter_sine(input int unsigned k,
                                                input int unsigned addr_bits,
                                                input longint unsigned amp);
      longint unsigned x;
      longint unsigned t;
      longint          s;
      longint          v;
      int unsigned     n;
      logic [127:0]    prod;
      x = (longint'(k) * HALF_PI_Q30) >> addr_bits;
      t = x;
      s = longint'(x);
      for (n = 1; n <= 7; n++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         prod = {64'd0, t} * {64'd0, taylor_recip(n)};
         t = prod[127:64];
         if (n[0]) begin
            s = s - longint'(t);
         end else begin
            s = s + longint'(t);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      if (s > (64'sd1 <<< 30)) begin
         s = 64'sd1 <<< 30;
      end
      v = (s * longint'(amp) + (64'sd1 <<< 29)) >>> 30;
      if (v > longint'(amp)) begin
         v = longint'(amp);
      end
      return int'(v);
   endfunction

endpackage

`default_nettype wire

/* rtl/fsk_channels.sv */
// request and response channel interfaces of the fsk modulator
`default_nettype none

interface fsk_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface fsk_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          sample_valid;
   logic                          last_of_byte;
   logic                          need_byte;

   modport source (output valid, output sample, output sample_valid,
                   output last_of_byte, output need_byte, input ready);
   modport sink   (input valid, input sample, input sample_valid,
                   input last_of_byte, input need_byte, output ready);
endinterface

`default_nettype wire

/* rtl/fsk_front.sv */
// front end: takes request beats, runs bit sequencing and the phase accumulator
`default_nettype none

module fsk_front #(
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   fsk_req_if.sink                         req,
   input  wire fsk_pkg::cfg_type           cfg,
   input  wire logic                       queue_full,
   output logic                            queue_push,
   output logic [SINE_ADDR_BITS+4:0]       queue_entry
);

   typedef struct packed {
      logic [SINE_ADDR_BITS:0] rom_addr;
      logic                    negate;
      logic                    sample_valid;
      logic                    last_of_byte;
      logic                    need_byte;
   } entry_type;

   logic [PHASE_BITS-1:0]                   phase_ff, phase_in;
   logic [fsk_pkg::BYTE_BITS-1:0]           bit_shift_ff, bit_shift_in;
   logic [fsk_pkg::COUNT_BITS-1:0]          bits_left_ff, bits_left_in;
   logic [fsk_pkg::SPB_BITS-1:0]            sample_in_bit_ff, sample_in_bit_in;

   logic [PHASE_BITS-1:0]                   space_step;
   logic [PHASE_BITS-1:0]                   mark_step;
   logic [fsk_pkg::SPB_BITS-1:0]            spb_eff;
   logic [fsk_pkg::SPB_BITS-1:0]            sib_next;
   logic                                    bit_end;
   logic [1:0]                              quadrant;
   logic [SINE_ADDR_BITS-1:0]               index;
   logic [SINE_ADDR_BITS:0]                 rom_addr;
   logic                                    accept;
   entry_type                               entry;

   // scale the 32-bit increments to the accumulator width
   if (PHASE_BITS >= fsk_pkg::INC_BITS) begin : g_scale_up
      assign space_step = PHASE_BITS'(cfg.space_increment) << (PHASE_BITS - fsk_pkg::INC_BITS);
      assign mark_step  = PHASE_BITS'(cfg.mark_increment) << (PHASE_BITS - fsk_pkg::INC_BITS);
   end else begin : g_scale_down
      assign space_step = cfg.space_increment[fsk_pkg::INC_BITS-1 -: PHASE_BITS];
      assign mark_step  = cfg.mark_increment[fsk_pkg::INC_BITS-1 -: PHASE_BITS];
   end

   assign accept     = req.valid && req.ready;
   assign req.ready  = !queue_full;
   assign queue_push = accept;
   assign queue_entry = entry;

   assign spb_eff  = (cfg.samples_per_bit == '0) ? fsk_pkg::SPB_BITS'(1) : cfg.samples_per_bit;
   assign sib_next = sample_in_bit_ff + fsk_pkg::SPB_BITS'(1);
   assign bit_end  = (sib_next >= spb_eff) || (sib_next == '0);

   // quadrant folding of the phase before its step
   assign quadrant = phase_ff[PHASE_BITS-1 -: 2];
   assign index    = phase_ff[PHASE_BITS-3 -: SINE_ADDR_BITS];
   assign rom_addr = quadrant[0] ? ({1'b1, {SINE_ADDR_BITS{1'b0}}} - {1'b0, index})
                                 : {1'b0, index};

   always_comb begin
      phase_in          = phase_ff;
      bit_shift_in      = bit_shift_ff;
      bits_left_in      = bits_left_ff;
      sample_in_bit_in  = sample_in_bit_ff;
      entry             = '0;
      entry.rom_addr    = rom_addr;
      entry.negate      = quadrant[1];
      if (accept) begin
         if (req.cmd == fsk_pkg::CMD_LOAD) begin
            if (bits_left_ff == '0) begin
               bit_shift_in     = req.data_byte;
               bits_left_in     = fsk_pkg::BITS_PER_BYTE;
               sample_in_bit_in = '0;
            end
         end else if (bits_left_ff != '0) begin
            entry.sample_valid = 1'b1;
            phase_in = phase_ff + (bit_shift_ff[fsk_pkg::BYTE_BITS-1] ? mark_step : space_step);
            sample_in_bit_in = sib_next;
            if (bit_end) begin
               sample_in_bit_in   = '0;
               bit_shift_in       = {bit_shift_ff[fsk_pkg::BYTE_BITS-2:0], 1'b0};
               bits_left_in       = bits_left_ff - fsk_pkg::COUNT_BITS'(1);
               entry.last_of_byte = (bits_left_ff == fsk_pkg::COUNT_BITS'(1));
            end
         end
      end
      entry.need_byte = (bits_left_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= '0;
         bit_shift_ff     <= '0;
         bits_left_ff     <= '0;
         sample_in_bit_ff <= '0;
      end else begin
         phase_ff         <= phase_in;
         bit_shift_ff     <= bit_shift_in;
         bits_left_ff     <= bits_left_in;
         sample_in_bit_ff <= sample_in_bit_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/fsk_queue.sv */
// small register queue between front and back
`default_nettype none

module fsk_queue #(
   parameter int WIDTH = 15
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  empty,
   output logic                  full
);

   logic [WIDTH-1:0]                      slot_ff [fsk_pkg::QUEUE_DEPTH];
   logic [fsk_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [fsk_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [fsk_pkg::QUEUE_PTR_BITS:0]      count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == (fsk_pkg::QUEUE_PTR_BITS+1)'(fsk_pkg::QUEUE_DEPTH));
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + fsk_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + fsk_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (fsk_pkg::QUEUE_PTR_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (fsk_pkg::QUEUE_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/fsk_sine_rom.sv */
// quarter-wave sine rom with registered read
`default_nettype none

module fsk_sine_rom #(
   parameter int SINE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS    = 16
) (
   input  wire logic                     clock,
   input  wire logic                     read_en,
   input  wire logic [SINE_ADDR_BITS:0]  read_addr,
   output logic [SAMPLE_BITS-2:0]        read_data
);

   localparam int DEPTH = (1 << SINE_ADDR_BITS) + 1;
   localparam longint unsigned AMP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

   logic [SAMPLE_BITS-2:0] rom_word [DEPTH];
   logic [SAMPLE_BITS-2:0] read_data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_word
      localparam int unsigned VALUE = fsk_pkg::quarter_sine(k, SINE_ADDR_BITS, AMP);
      assign rom_word[k] = VALUE[SAMPLE_BITS-2:0];
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= rom_word[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

/* rtl/fsk_back.sv */
// back end: sine lookup, sign restore and the response output register
`default_nettype none

module fsk_back #(
   parameter int SINE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS    = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       queue_empty,
   input  wire logic [SINE_ADDR_BITS+4:0]  queue_head,
   output logic                            queue_pop,
   fsk_rsp_if.source                       rsp
);

   typedef struct packed {
      logic [SINE_ADDR_BITS:0] rom_addr;
      logic                    negate;
      logic                    sample_valid;
      logic                    last_of_byte;
      logic                    need_byte;
   } entry_type;

   entry_type                      head;
   logic                           lookup_valid_ff, lookup_valid_in;
   entry_type                      lookup_ff;
   logic [SAMPLE_BITS-2:0]         rom_data;
   logic                           out_ready;
   logic [SAMPLE_BITS-1:0]         magnitude;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]  sample_ff;
   logic                           sample_valid_ff;
   logic                           last_of_byte_ff;
   logic                           need_byte_ff;

   assign head      = queue_head;
   assign out_ready = !rsp_valid_ff || rsp.ready;
   assign queue_pop = !queue_empty && (!lookup_valid_ff || out_ready);

   fsk_sine_rom #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_rom (
      .clock     (clock),
      .read_en   (queue_pop),
      .read_addr (head.rom_addr),
      .read_data (rom_data)
   );

   assign magnitude = {1'b0, rom_data};

   always_comb begin
      lookup_valid_in = lookup_valid_ff;
      if (queue_pop) begin
         lookup_valid_in = 1'b1;
      end else if (out_ready) begin
         lookup_valid_in = 1'b0;
      end
      rsp_valid_in = out_ready ? lookup_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         lookup_valid_ff <= lookup_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         lookup_ff <= head;
      end
      if (lookup_valid_ff && out_ready) begin
         if (!lookup_ff.sample_valid) begin
            sample_ff <= '0;
         end else if (lookup_ff.negate) begin
            sample_ff <= -magnitude;
         end else begin
            sample_ff <= magnitude;
         end
         sample_valid_ff <= lookup_ff.sample_valid;
         last_of_byte_ff <= lookup_ff.last_of_byte;
         need_byte_ff    <= lookup_ff.need_byte;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sample       = sample_ff;
   assign rsp.sample_valid = sample_valid_ff;
   assign rsp.last_of_byte = last_of_byte_ff;
   assign rsp.need_byte    = need_byte_ff;

endmodule

`default_nettype wire

/* rtl/fsk_tone_modulator_core.sv */
// top level of the phase-continuous binary fsk modulator
//
// usage:
//   req channel: each beat is a load (cmd 0, data_byte) or a tick (cmd 1).
//   a load stores a byte that is then sent msb first, samples_per_bit ticks
//   per bit; a load while bits remain is dropped. every tick while bits remain
//   gives one sine sample of the phase before its step; an idle tick gives
//   sample 0 with sample_valid clear and leaves the phase where it is.
//   rsp channel: exactly one beat per req beat, in order.
//   csr port: write space_increment, mark_increment, samples_per_bit while
//   the block is idle; no read-back.
// timing:
//   one req beat per cycle sustained while the queue has room; a response is
//   registered in a queue slot, the rom read register and the output register.
//   the rate is set by the phase accumulator add in the front end.
// reset: phase, bit sequencing, queue and output valid clear; increments go to 0
//   and samples_per_bit to 441.
// stall: when rsp.ready is low the output holds, the lookup stage and the
//   four-beat queue fill up, and req.ready drops once the queue is full.
`default_nettype none

module fsk_tone_modulator_core #(
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS    = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   fsk_req_if.sink                                  req,
   fsk_rsp_if.source                                rsp,
   input  wire logic                                csr_write_en,
   input  wire logic [fsk_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [fsk_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // queue entry: rom address, negate, sample_valid, last_of_byte, need_byte
   localparam int ENTRY_BITS = SINE_ADDR_BITS + 5;

   fsk_pkg::cfg_type          cfg_ff, cfg_in;
   logic                      queue_push;
   logic                      queue_pop;
   logic                      queue_empty;
   logic                      queue_full;
   logic [ENTRY_BITS-1:0]     push_entry;
   logic [ENTRY_BITS-1:0]     head_entry;

   // configuration registers, unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (fsk_pkg::csr_index_type'(csr_index))
            fsk_pkg::CSR_SPACE_INCREMENT: begin
               cfg_in.space_increment = csr_wdata[fsk_pkg::INC_BITS-1:0];
            end
            fsk_pkg::CSR_MARK_INCREMENT: begin
               cfg_in.mark_increment = csr_wdata[fsk_pkg::INC_BITS-1:0];
            end
            fsk_pkg::CSR_SAMPLES_PER_BIT: begin
               cfg_in.samples_per_bit = csr_wdata[fsk_pkg::SPB_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.space_increment <= '0;
         cfg_ff.mark_increment  <= '0;
         cfg_ff.samples_per_bit <= fsk_pkg::SPB_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: bit sequencing and phase accumulation
   fsk_front #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .cfg         (cfg_ff),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry)
   );

   // decouples the front from response backpressure
   fsk_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_entry),
      .pop       (queue_pop),
      .head_data (head_entry),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // back: table lookup and output register
   fsk_back #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (head_entry),
      .queue_pop   (queue_pop),
      .rsp         (rsp)
   );

endmodule

`default_nettype wire

/* verif/fsk_tone_modulator_core_test.sv */
// self-checking testbench for fsk_tone_modulator_core: predicts and checks every response beat
`default_nettype none

module fsk_tone_modulator_core_test;

   localparam int CLOCK_HALF         = 4;
   localparam int RESET_CYCLES       = 7;
   // no beat moves on either channel for this long: the block is hung
   localparam int STALL_LIMIT        = 2000;
   // settling time at the end so that stray response beats still show up
   localparam int SETTLE_CYCLES      = 12;
   localparam int RANDOM_PHASE_BEATS = 80;
   localparam int WAVE_POINTS        = 1024;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam longint ONE_Q30   = 64'sd1073741824;
   localparam longint HALF_LSB  = 64'sd536870912;
   localparam longint FULL_SCALE = 64'sd32767;

   // one response beat as the block should present it
   typedef struct packed {
      logic signed [15:0] sample;
      logic               sample_valid;
      logic               last_of_byte;
      logic               need_byte;
   } tone_beat_type;

   // receiver back-pressure styles
   typedef enum int {
      SINK_OPEN,
      SINK_COIN,
      SINK_SPARSE,
      SINK_STARVED
   } sink_mode_type;

   // tracks the modulator state and the response beats still owed by the block
   class tone_ledger_type;
      int unsigned quarter_wave [0:WAVE_POINTS];
      logic [31:0] space_step;
      logic [31:0] mark_step;
      logic [15:0] ticks_per_bit;
      logic [31:0] phase_acc;
      logic [7:0]  shift_reg;
      logic [3:0]  bits_left;
      logic [15:0] tick_in_bit;
      tone_beat_type owed_beats [$];
      int unsigned errors;

      function new();
         longint unsigned k;
         longint unsigned x;
         longint unsigned t;
         longint          s;
         longint          v;
         int unsigned     n;
         // quarter sine by taylor series in q30, rounded to full scale
         for (k = 0; k <= WAVE_POINTS; k++) begin
            x = (k * QUARTER_TURN_Q30) >> 10;
            t = x;
            s = longint'(x);
            for (n = 1; n <= 7; n++) begin
               t = (t * x) >> 30;
               t = (t * x) >> 30;
               t = t / longint'((2 * n) * (2 * n + 1));
               s = (n % 2 == 1) ? s - longint'(t) : s + longint'(t);
            end
            if (s < 0) s = 0;
            if (s > ONE_Q30) s = ONE_Q30;
            v = (s * FULL_SCALE + HALF_LSB) >>> 30;
            if (v > FULL_SCALE) v = FULL_SCALE;
            quarter_wave[k] = int'(v);
         end
         space_step    = '0;
         mark_step     = '0;
         ticks_per_bit = 16'd441;
         phase_acc     = '0;
         shift_reg     = '0;
         bits_left     = '0;
         tick_in_bit   = '0;
         errors        = 0;
      endfunction

      function logic signed [15:0] sine_of(logic [31:0] p);
         logic [9:0]  idx;
         int unsigned mag;
         idx = p[29:20];
         mag = p[30] ? quarter_wave[WAVE_POINTS - idx] : quarter_wave[idx];
         return p[31] ? -16'(mag) : 16'(mag);
      endfunction

      function void set_register(fsk_pkg::csr_index_type idx, logic [31:0] value);
         unique case (idx)
            fsk_pkg::CSR_SPACE_INCREMENT: space_step    = value;
            fsk_pkg::CSR_MARK_INCREMENT:  mark_step     = value;
            fsk_pkg::CSR_SAMPLES_PER_BIT: ticks_per_bit = value[15:0];
            default: ;
         endcase
      endfunction

      function void take_request(fsk_pkg::cmd_type cmd, logic [7:0] data);
         tone_beat_type beat;
         logic [15:0]   bit_len;
         beat = '0;
         if (cmd == fsk_pkg::CMD_LOAD) begin
            if (bits_left == 0) begin
               shift_reg   = data;
               bits_left   = 4'd8;
               tick_in_bit = '0;
            end
         end else if (bits_left != 0) begin
            bit_len           = (ticks_per_bit == 0) ? 16'd1 : ticks_per_bit;
            beat.sample       = sine_of(phase_acc);
            beat.sample_valid = 1'b1;
            phase_acc         = phase_acc + (shift_reg[7] ? mark_step : space_step);
            tick_in_bit       = tick_in_bit + 16'd1;
            if (tick_in_bit >= bit_len || tick_in_bit == 0) begin
               tick_in_bit       = '0;
               shift_reg         = shift_reg << 1;
               bits_left         = bits_left - 4'd1;
               beat.last_of_byte = (bits_left == 0);
            end
         end
         beat.need_byte = (bits_left == 0);
         owed_beats = {owed_beats, beat};
      endfunction

      task report(string what);
         if (errors < 60) $display("%0t: mismatch: %s", $time, what);
         errors++;
      endtask

      task match_response(tone_beat_type seen);
         tone_beat_type want;
         if (owed_beats.size() == 0) begin
            report($sformatf("response beat with nothing owed: %p", seen));
            return;
         end
         want = owed_beats.pop_front();
         if (seen.sample !== want.sample)
            report($sformatf("sample %0d, want %0d", seen.sample, want.sample));
         if (seen.sample_valid !== want.sample_valid)
            report($sformatf("sample_valid %b, want %b", seen.sample_valid, want.sample_valid));
         if (seen.last_of_byte !== want.last_of_byte)
            report($sformatf("last_of_byte %b, want %b", seen.last_of_byte, want.last_of_byte));
         if (seen.need_byte !== want.need_byte)
            report($sformatf("need_byte %b, want %b", seen.need_byte, want.need_byte));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   fsk_pkg::csr_index_type csr_index;
   logic [31:0]            csr_wdata;

   fsk_req_if                     req_ch ();
   fsk_rsp_if #(.SAMPLE_BITS(16)) rsp_ch ();

   tone_ledger_type ledger;
   int unsigned     quiet_cycles;
   int unsigned     burst_left;
   logic [15:0]     cur_spb;
   sink_mode_type   sink_mode;
   int unsigned     sink_hold;

   fsk_tone_modulator_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // both channels are watched in one place so that a request is always noted
   // before any response of the same edge is checked
   always @(posedge clock) begin : beat_monitor
      logic took_req;
      logic took_rsp;
      took_req = req_ch.valid && req_ch.ready;
      took_rsp = rsp_ch.valid && rsp_ch.ready;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (took_req) ledger.take_request(fsk_pkg::cmd_type'(req_ch.cmd), req_ch.data_byte);
         if (took_rsp) ledger.match_response(tone_beat_type'{rsp_ch.sample,
                                                             rsp_ch.sample_valid,
                                                             rsp_ch.last_of_byte,
                                                             rsp_ch.need_byte});
         quiet_cycles <= (took_req || took_rsp) ? 0 : quiet_cycles + 1;
      end
   end

   // receiver: each stretch of random length picks a stall style,
   // from always ready down to a beat now and then
   always @(posedge clock) begin
      if (sink_hold == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_hold <= $urandom_range(20, 150);
      end else begin
         sink_hold <= sink_hold - 1;
      end
      unique case (sink_mode)
         SINK_OPEN:   rsp_ch.ready <= 1'b1;
         SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ch.ready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   // hang detector
   initial begin
      do @(negedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("fsk_tone_modulator_core verification failed");
      $finish;
   end

   // sender gap: valid low, payload scrambled
   task automatic pause_sender(int unsigned cycles);
      if (cycles != 0) begin
         req_ch.valid     <= 1'b0;
         req_ch.cmd       <= fsk_pkg::cmd_type'($urandom_range(0, 1));
         req_ch.data_byte <= 8'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   // one request beat; returns at the edge that takes it, valid left high
   task automatic send_beat(fsk_pkg::cmd_type cmd, logic [7:0] data);
      if (burst_left == 0) begin
         pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
         // mostly short bursts, now and then a long gapless run
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= cmd;
      req_ch.data_byte <= data;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold the sender until every owed response beat is back
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (ledger.owed_beats.size() != 0);
      @(posedge clock);
   endtask

   // all three registers, back to back; only called with nothing in flight
   task automatic write_settings(logic [31:0] space_step, logic [31:0] mark_step,
                                 logic [15:0] spb);
      csr_write_en <= 1'b1;
      csr_index    <= fsk_pkg::CSR_SPACE_INCREMENT;
      csr_wdata    <= space_step;
      @(posedge clock);
      csr_index    <= fsk_pkg::CSR_MARK_INCREMENT;
      csr_wdata    <= mark_step;
      @(posedge clock);
      csr_index    <= fsk_pkg::CSR_SAMPLES_PER_BIT;
      csr_wdata    <= 32'(spb);
      @(posedge clock);
      csr_write_en <= 1'b0;
      ledger.set_register(fsk_pkg::CSR_SPACE_INCREMENT, space_step);
      ledger.set_register(fsk_pkg::CSR_MARK_INCREMENT, mark_step);
      ledger.set_register(fsk_pkg::CSR_SAMPLES_PER_BIT, 32'(spb));
      cur_spb = spb;
   endtask

   // mostly whole bytes: a load and then enough ticks to send all 8 bits;
   // some bytes cut short, some followed by idle ticks, stray loads mid-byte
   // and a share of pure noise beats
   task automatic run_random_phase(int unsigned beats);
      int unsigned sent;
      int unsigned span;
      int unsigned k;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(0, 9) == 0) begin
            send_beat(fsk_pkg::cmd_type'($urandom_range(0, 1)), 8'($urandom));
            sent++;
         end else begin
            span = 8 * ((cur_spb == 0) ? 1 : cur_spb);
            case ($urandom_range(0, 6))
               0:       span = $urandom_range(1, span);
               1:       span = span + $urandom_range(1, 3);
               default: ;
            endcase
            send_beat(fsk_pkg::CMD_LOAD, 8'($urandom));
            sent++;
            for (k = 0; k < span; k++) begin
               if ($urandom_range(0, 19) == 0) begin
                  // load while the byte is still going out, must be dropped
                  send_beat(fsk_pkg::CMD_LOAD, 8'($urandom));
                  sent++;
               end
               send_beat(fsk_pkg::CMD_TICK, 8'($urandom));
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = fsk_pkg::CSR_SPACE_INCREMENT;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = fsk_pkg::CMD_TICK;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      sink_mode        = SINK_OPEN;
      sink_hold        = 0;
      quiet_cycles     = 0;
      burst_left       = 0;
      cur_spb          = 16'd441;
      ledger           = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: both steps zero, 441 ticks per bit
      send_beat(fsk_pkg::CMD_TICK, 8'h00);   // idle tick
      send_beat(fsk_pkg::CMD_LOAD, 8'h00);
      send_beat(fsk_pkg::CMD_LOAD, 8'hFF);   // byte still going out, dropped
      send_beat(fsk_pkg::CMD_TICK, 8'hFF);
      send_beat(fsk_pkg::CMD_TICK, 8'h00);
      drain_responses();

      // zero ticks per bit acts as one; quarter-turn space step gives the
      // full-scale peaks, the mark step is one lsb short of a full turn
      write_settings(32'h4000_0000, 32'hFFFF_FFFF, 16'd0);
      repeat (8) send_beat(fsk_pkg::CMD_TICK, 8'h5A);   // rest of the zero byte
      send_beat(fsk_pkg::CMD_TICK, 8'hA5);              // idle tick
      send_beat(fsk_pkg::CMD_LOAD, 8'h80);
      repeat (8) send_beat(fsk_pkg::CMD_TICK, 8'h00);
      send_beat(fsk_pkg::CMD_LOAD, 8'h7F);
      drain_responses();

      // step extremes
      write_settings(32'h0000_0000, 32'hFFFF_FFFF, 16'd1);
      run_random_phase(RANDOM_PHASE_BEATS);
      drain_responses();
      write_settings(32'hFFFF_FFFF, 32'h0000_0000, 16'd2);
      run_random_phase(RANDOM_PHASE_BEATS);
      drain_responses();
      write_settings(32'h8000_0000, 32'h4000_0000, 16'd3);
      run_random_phase(RANDOM_PHASE_BEATS);
      drain_responses();

      repeat (6) begin
         write_settings($urandom, $urandom, 16'($urandom_range(1, 6)));
         run_random_phase(RANDOM_PHASE_BEATS);
         drain_responses();
      end

      // long bit: one bit end deep into the tick count, the byte left mostly unsent
      write_settings($urandom, $urandom, 16'd100);
      send_beat(fsk_pkg::CMD_LOAD, 8'hC3);
      repeat (150) send_beat(fsk_pkg::CMD_TICK, 8'($urandom));
      drain_responses();

      // the byte left mostly unsent above finishes at a short bit length
      write_settings($urandom, $urandom, 16'($urandom_range(1, 4)));
      run_random_phase(RANDOM_PHASE_BEATS);
      drain_responses();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.owed_beats.size() != 0)
         ledger.report($sformatf("%0d response beats never came", ledger.owed_beats.size()));
      if (ledger.errors == 0) begin
         $display("fsk_tone_modulator_core verification clean");
      end else begin
         $display("fsk_tone_modulator_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
